[rtl/core/phd_pkg.sv]
// Package for the planning horizon distance core.
// Holds the shared constants, the failure codes and the register indexes.
// No dependencies.
package phd_pkg;

   localparam int PHD_DIST_BITS = 24;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 24;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MIN_DISTANCE    = 3'd0,
      CSR_MAX_DISTANCE    = 3'd1,
      CSR_PREVIEW_TIME    = 3'd2,
      CSR_STOP_FACTOR     = 3'd3,
      CSR_BOUNDARY_MARGIN = 3'd4,
      CSR_TOLERANCE       = 3'd5
   } csr_idx_type;

   typedef enum logic [2:0] {
      FAIL_NONE     = 3'd0,
      FAIL_INVALID  = 3'd1,
      FAIL_BACKWARD = 3'd2,
      FAIL_TERMINAL = 3'd3,
      FAIL_NO_SPACE = 3'd4
   } fail_type;

   localparam logic [15:0] STOP_FACTOR_RESET = 16'd256;

   // floor(x / 1000) = ((x >> 3) * RECIP_125) >> RECIP_SHIFT for x < 2**32
   localparam logic [29:0] RECIP_125   = 30'd549755814;
   localparam int          RECIP_SHIFT = 36;

   // register stages: check, multiply, scale, 32 divide steps, sum, factor, clamp, output
   localparam int DIV_STEPS = 32;
   localparam int NUM_STG   = 3 + DIV_STEPS + 4;

endpackage

[rtl/core/planning_horizon_distance_core.sv]
// A request passes the check, multiply, scale, divide, sum, factor, clamp and output registers to rsp_valid.
// Throughput: one request per cycle unless stalled on rsp_ready; the 32-step
// restoring divider for the stopping distance sets the depth, one quotient bit per stage.
// The whole pipeline holds while a result waits on rsp_ready.
// Reset clears all valid bits and loads the register reset values.
module planning_horizon_distance_core
   import phd_pkg::*;
#(
   parameter int DIST_BITS = PHD_DIST_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [24:0]        req_start_arc,
   input  logic [23:0]               req_route_length,
   input  logic                      req_previous_valid,
   input  logic signed [24:0]        req_previous_arc,
   input  logic                      req_terminal_valid,
   input  logic signed [24:0]        req_terminal_arc,
   input  logic                      req_usable_limited,
   input  logic signed [24:0]        req_usable_limit,
   input  logic [15:0]               req_speed,
   input  logic [15:0]               req_max_decel,
   input  logic [15:0]               req_latency,
   input  logic [23:0]               req_stop_margin,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_success,
   output logic [2:0]                rsp_failure_code,
   output logic signed [24:0]        rsp_start_out,
   output logic signed [25:0]        rsp_endpoint_arc,
   output logic [23:0]               rsp_forward_distance,
   output logic [23:0]               rsp_unconstrained_distance,
   output logic [23:0]               rsp_usable_distance,
   output logic                      rsp_terminal_clamped,
   output logic                      rsp_shortened
);

   localparam int DW = DIST_BITS;
   localparam logic signed [33:0] DMAX_S = (34'sd1 <<< DIST_BITS) - 34'sd1;
   localparam logic [47:0]        DMAX_W = (48'd1 << DIST_BITS) - 48'd1;

   typedef struct packed {
      logic [2:0]         code;
      logic signed [24:0] start;
      logic               term_use;
      logic [25:0]        dist_t;
      logic [DW-1:0]      usable;
      logic [23:0]        smargin;
      logic [15:0]        spd;
      logic [15:0]        dec;
      logic [15:0]        lat;
      logic [31:0]        num;
      logic [31:0]        vl;
      logic [31:0]        vp;
      logic [17:0]        rem;
      logic [22:0]        vlq;
      logic [22:0]        vpq;
      logic [DW-1:0]      stop;
      logic [DW-1:0]      preview;
      logic [DW-1:0]      fstop;
      logic [DW-1:0]      unc;
   } ctx_type;

   logic [23:0] min_ff, max_ff, margin_ff;
   logic [15:0] preview_ff, factor_ff, tol_ff;

   logic [NUM_STG-1:0] vld_ff;
   logic [NUM_STG-1:0] vld_in;
   ctx_type            ctx_ff [NUM_STG-1];
   ctx_type            ctx_in [NUM_STG-1];

   logic                adv;
   logic                rsp_success_ff, rsp_success_in;
   logic [2:0]          rsp_code_ff, rsp_code_in;
   logic signed [24:0]  rsp_start_ff, rsp_start_in;
   logic signed [25:0]  rsp_end_ff, rsp_end_in;
   logic [23:0]         rsp_fwd_ff, rsp_fwd_in;
   logic [23:0]         rsp_unc_ff, rsp_unc_in;
   logic [23:0]         rsp_use_ff, rsp_use_in;
   logic                rsp_tcl_ff, rsp_tcl_in;
   logic                rsp_shr_ff, rsp_shr_in;

   // stage 0 signals
   logic signed [33:0] s_start, s_rlen_tol, s_tol, s_prev, s_term, s_ulim, s_dts;
   logic signed [33:0] s_u0, s_lim, s_um, s_usable;
   logic [2:0]         s_code;

   // later stage signals
   logic [58:0]        p_vl, p_vp;
   logic [17:0]        d_rsh [DIV_STEPS];
   logic [17:0]        d_div [DIV_STEPS];
   logic [33:0]        sum_stop;
   logic [47:0]        fprod;
   logic [39:0]        fshift;
   logic [DW-1:0]      mn, mx, u1, u2;
   logic [33:0]        f_fwd, f_unc, f_tol, f_dt, f_use;
   logic               f_tcl, f_fail4;

   function automatic logic [DW-1:0] sat_s(input logic signed [33:0] x);
      if (x < 34'sd0) begin
         sat_s = '0;
      end else if (x > DMAX_S) begin
         sat_s = DMAX_S[DW-1:0];
      end else begin
         sat_s = x[DW-1:0];
      end
   endfunction

   function automatic logic [DW-1:0] sat_u(input logic [47:0] x);
      if (x > DMAX_W) begin
         sat_u = DMAX_W[DW-1:0];
      end else begin
         sat_u = x[DW-1:0];
      end
   endfunction

   assign adv       = !vld_ff[NUM_STG-1] || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff     <= '0;
         max_ff     <= '0;
         preview_ff <= '0;
         factor_ff  <= STOP_FACTOR_RESET;
         margin_ff  <= '0;
         tol_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_DISTANCE:    min_ff     <= csr_wdata;
            CSR_MAX_DISTANCE:    max_ff     <= csr_wdata;
            CSR_PREVIEW_TIME:    preview_ff <= csr_wdata[15:0];
            CSR_STOP_FACTOR:     factor_ff  <= csr_wdata[15:0];
            CSR_BOUNDARY_MARGIN: margin_ff  <= csr_wdata;
            CSR_TOLERANCE:       tol_ff     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // checks, usable space and terminal distance
   always_comb begin
      s_start    = 34'(req_start_arc);
      s_tol      = 34'(tol_ff);
      s_rlen_tol = 34'(req_route_length) + s_tol;
      s_prev     = 34'(req_previous_arc);
      s_term     = 34'(req_terminal_arc);
      s_ulim     = 34'(req_usable_limit);
      s_dts      = s_term - s_start;
      priority if (max_ff < min_ff || s_start < -s_tol || s_start > s_rlen_tol ||
                   req_max_decel == 16'd0 || (req_usable_limited && s_ulim < 34'sd0)) begin
         s_code = FAIL_INVALID;
      end else if (req_previous_valid && (s_prev < 34'sd0 || s_prev > s_rlen_tol)) begin
         s_code = FAIL_INVALID;
      end else if (req_previous_valid && s_start + s_tol < s_prev) begin
         s_code = FAIL_BACKWARD;
      end else if (req_terminal_valid && (s_term < 34'sd0 || s_term > s_rlen_tol)) begin
         s_code = FAIL_INVALID;
      end else if (req_terminal_valid && s_term + s_tol < s_start) begin
         s_code = FAIL_TERMINAL;
      end else begin
         s_code = FAIL_NONE;
      end
      s_u0  = 34'(sat_s(34'(req_route_length) - s_start));
      s_lim = s_ulim - 34'(margin_ff);
      s_um  = (s_lim < s_u0) ? s_lim : s_u0;
      s_usable = req_usable_limited ? 34'(sat_s(s_um)) : s_u0;
   end

   always_comb begin
      ctx_in[0]          = ctx_ff[0];
      ctx_in[0].code     = s_code;
      ctx_in[0].start    = req_start_arc;
      ctx_in[0].term_use = req_terminal_valid && (s_dts <= s_usable + s_tol);
      ctx_in[0].dist_t   = (s_dts < 34'sd0) ? 26'd0 : s_dts[25:0];
      ctx_in[0].usable   = s_usable[DW-1:0];
      ctx_in[0].smargin  = req_stop_margin;
      ctx_in[0].spd      = req_speed;
      ctx_in[0].dec      = req_max_decel;
      ctx_in[0].lat      = req_latency;

      ctx_in[1]     = ctx_ff[0];
      ctx_in[1].num = 32'(ctx_ff[0].spd) * 32'(ctx_ff[0].spd);
      ctx_in[1].vl  = 32'(ctx_ff[0].spd) * 32'(ctx_ff[0].lat);
      ctx_in[1].vp  = 32'(ctx_ff[0].spd) * 32'(preview_ff);

      p_vl = 59'(ctx_ff[1].vl[31:3]) * 59'(RECIP_125);
      p_vp = 59'(ctx_ff[1].vp[31:3]) * 59'(RECIP_125);
      ctx_in[2]     = ctx_ff[1];
      ctx_in[2].vlq = p_vl[RECIP_SHIFT +: 23];
      ctx_in[2].vpq = p_vp[RECIP_SHIFT +: 23];
      ctx_in[2].rem = '0;

      for (int k = 0; k < DIV_STEPS; k++) begin
         d_rsh[k] = {ctx_ff[2+k].rem[16:0], ctx_ff[2+k].num[31]};
         d_div[k] = {1'b0, ctx_ff[2+k].dec, 1'b0};
         ctx_in[3+k] = ctx_ff[2+k];
         if (d_rsh[k] >= d_div[k]) begin
            ctx_in[3+k].rem = d_rsh[k] - d_div[k];
            ctx_in[3+k].num = {ctx_ff[2+k].num[30:0], 1'b1};
         end else begin
            ctx_in[3+k].rem = d_rsh[k];
            ctx_in[3+k].num = {ctx_ff[2+k].num[30:0], 1'b0};
         end
      end

      sum_stop = 34'(ctx_ff[2+DIV_STEPS].num) + 34'(ctx_ff[2+DIV_STEPS].vlq)
               + 34'(ctx_ff[2+DIV_STEPS].smargin);
      ctx_in[3+DIV_STEPS]      = ctx_ff[2+DIV_STEPS];
      ctx_in[3+DIV_STEPS].stop = sat_u(48'(sum_stop));

      fprod  = 48'(factor_ff) * 48'(ctx_ff[3+DIV_STEPS].stop);
      fshift = fprod[47:8];
      ctx_in[4+DIV_STEPS]         = ctx_ff[3+DIV_STEPS];
      ctx_in[4+DIV_STEPS].fstop   = sat_u(48'(fshift));
      ctx_in[4+DIV_STEPS].preview = sat_u(48'(ctx_ff[3+DIV_STEPS].vpq));

      mn = sat_u(48'(min_ff));
      mx = sat_u(48'(max_ff));
      u1 = (ctx_ff[4+DIV_STEPS].preview > mn) ? ctx_ff[4+DIV_STEPS].preview : mn;
      u1 = (ctx_ff[4+DIV_STEPS].fstop > u1) ? ctx_ff[4+DIV_STEPS].fstop : u1;
      u1 = (u1 > mx) ? mx : u1;
      u2 = (u1 < mn) ? mn : u1;
      ctx_in[5+DIV_STEPS]     = ctx_ff[4+DIV_STEPS];
      ctx_in[5+DIV_STEPS].unc = u2;
   end

   // final selection into the output register
   always_comb begin
      f_unc = 34'(ctx_ff[NUM_STG-2].unc);
      f_tol = 34'(tol_ff);
      f_dt  = 34'(ctx_ff[NUM_STG-2].dist_t);
      f_use = 34'(ctx_ff[NUM_STG-2].usable);
      if (ctx_ff[NUM_STG-2].term_use) begin
         f_fwd = (f_dt < f_unc) ? f_dt : f_unc;
         f_tcl = f_dt <= f_unc + f_tol;
      end else begin
         f_fwd = (f_use < f_unc) ? f_use : f_unc;
         f_tcl = 1'b0;
      end
      f_fail4 = (f_fwd == 34'd0) && !ctx_ff[NUM_STG-2].term_use;
      rsp_start_in = ctx_ff[NUM_STG-2].start;
      if (ctx_ff[NUM_STG-2].code != FAIL_NONE || f_fail4) begin
         rsp_success_in = 1'b0;
         rsp_code_in    = (ctx_ff[NUM_STG-2].code != FAIL_NONE) ?
                          ctx_ff[NUM_STG-2].code : FAIL_NO_SPACE;
         rsp_end_in     = 26'(ctx_ff[NUM_STG-2].start);
         rsp_fwd_in     = '0;
         rsp_unc_in     = '0;
         rsp_use_in     = '0;
         rsp_tcl_in     = 1'b0;
         rsp_shr_in     = 1'b0;
      end else begin
         rsp_success_in = 1'b1;
         rsp_code_in    = FAIL_NONE;
         rsp_end_in     = 26'(34'(ctx_ff[NUM_STG-2].start) + f_fwd);
         rsp_fwd_in     = f_fwd[23:0];
         rsp_unc_in     = f_unc[23:0];
         rsp_use_in     = f_use[23:0];
         rsp_tcl_in     = f_tcl;
         rsp_shr_in     = (f_fwd + f_tol < f_unc) && !f_tcl;
      end
   end

   always_comb begin
      vld_in = {vld_ff[NUM_STG-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NUM_STG-1; i++) begin
            ctx_ff[i] <= ctx_in[i];
         end
         rsp_success_ff <= rsp_success_in;
         rsp_code_ff    <= rsp_code_in;
         rsp_start_ff   <= rsp_start_in;
         rsp_end_ff     <= rsp_end_in;
         rsp_fwd_ff     <= rsp_fwd_in;
         rsp_unc_ff     <= rsp_unc_in;
         rsp_use_ff     <= rsp_use_in;
         rsp_tcl_ff     <= rsp_tcl_in;
         rsp_shr_ff     <= rsp_shr_in;
      end
   end

   assign rsp_valid                  = vld_ff[NUM_STG-1];
   assign rsp_success                = rsp_success_ff;
   assign rsp_failure_code           = rsp_code_ff;
   assign rsp_start_out              = rsp_start_ff;
   assign rsp_endpoint_arc           = rsp_end_ff;
   assign rsp_forward_distance       = rsp_fwd_ff;
   assign rsp_unconstrained_distance = rsp_unc_ff;
   assign rsp_usable_distance        = rsp_use_ff;
   assign rsp_terminal_clamped       = rsp_tcl_ff;
   assign rsp_shortened              = rsp_shr_ff;

endmodule

[rtl/core/phd_checker.sv]
// Port-level checker for the planning horizon distance core.
// Depends on phd_pkg; bound to planning_horizon_distance_core below.
module phd_checker
   import phd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_success,
   input logic [2:0]         rsp_failure_code,
   input logic signed [24:0] rsp_start_out,
   input logic signed [25:0] rsp_endpoint_arc,
   input logic [23:0]        rsp_forward_distance,
   input logic [23:0]        rsp_unconstrained_distance
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_endpoint_arc))
      else $error("result dropped or changed while stalled");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_success == (rsp_failure_code == FAIL_NONE))
      else $error("success does not match failure code");

   a_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_success |->
         rsp_forward_distance == 24'd0 && rsp_endpoint_arc == 26'(rsp_start_out))
      else $error("failed result carries a distance");

   a_fwd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_success |-> rsp_forward_distance <= rsp_unconstrained_distance)
      else $error("forward distance above unconstrained distance");

endmodule

bind planning_horizon_distance_core phd_checker u_phd_checker (
   .clock                      (clock),
   .reset                      (reset),
   .rsp_valid                  (rsp_valid),
   .rsp_ready                  (rsp_ready),
   .rsp_success                (rsp_success),
   .rsp_failure_code           (rsp_failure_code),
   .rsp_start_out              (rsp_start_out),
   .rsp_endpoint_arc           (rsp_endpoint_arc),
   .rsp_forward_distance       (rsp_forward_distance),
   .rsp_unconstrained_distance (rsp_unconstrained_distance)
);
